### hw/rtl/brf_pkg.sv
// shared constants, codes and control types for the byte ring fifo
`timescale 1ns / 1ps

package brf_pkg;

   // storage geometry
   localparam int DEPTH_LOG2 = 10;
   localparam int MAX_DEPTH  = 1 << DEPTH_LOG2;
   localparam int LEVEL_W    = DEPTH_LOG2 + 1;

   // burst limits
   localparam int MAX_BURST = 16;
   localparam int LEN_W     = 5;
   localparam int BURST_W   = 5;

   // capacity register
   localparam int CAP_W = 4;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH_LOG2);

   // transaction kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_POP   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_CLEAR = 2'd3
   } brf_action_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_BURST
   } brf_state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic issue;
      logic load_byte;
      logic load_single;
   } brf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic burst_grant;
      logic out_free;
      logic pending;
      logic issue_left;
      logic last_load;
   } brf_status_type;

endpackage

### hw/rtl/brf_ctrl.sv
// controller state machine sequencing single results and read bursts
`timescale 1ns / 1ps

module brf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  brf_pkg::brf_status_type status,
   output brf_pkg::brf_cmd_type    cmd
);

   brf_pkg::brf_state_type state_ff;
   brf_pkg::brf_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.burst_grant ? brf_pkg::ST_BURST : brf_pkg::ST_SINGLE;
            end
         end
         brf_pkg::ST_SINGLE: begin
            if (status.out_free) begin
               state_in = brf_pkg::ST_IDLE;
            end
         end
         brf_pkg::ST_BURST: begin
            if (status.pending && status.out_free && status.last_load) begin
               state_in = brf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brf_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         brf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         brf_pkg::ST_SINGLE: begin
            cmd.load_single = status.out_free;
         end
         brf_pkg::ST_BURST: begin
            cmd.load_byte = status.pending && status.out_free;
            cmd.issue     = status.issue_left && (!status.pending || cmd.load_byte);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### hw/rtl/brf_dp.sv
// datapath: byte store, pointers, fill count, burst counters and result register
`timescale 1ns / 1ps

module brf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [brf_pkg::CAP_W-1:0]     csr_wr_data,
   input  brf_pkg::brf_action_type       action,
   input  logic [7:0]                    data_byte,
   input  logic [brf_pkg::LEN_W-1:0]     read_length,
   input  brf_pkg::brf_cmd_type          cmd,
   output brf_pkg::brf_status_type       status,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic                          rsp_accepted,
   output logic [brf_pkg::LEVEL_W-1:0]   rsp_level
);

   localparam int AW = brf_pkg::DEPTH_LOG2;
   localparam int LW = brf_pkg::LEVEL_W;
   localparam int BW = brf_pkg::BURST_W;

   logic [7:0] mem [brf_pkg::MAX_DEPTH];

   logic [brf_pkg::CAP_W-1:0] cap_log2_ff;
   logic [AW-1:0]             rp_ff, rp_in;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [LW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [BW-1:0]             issue_cnt_ff, issue_cnt_in;
   logic [BW-1:0]             load_cnt_ff, load_cnt_in;
   logic                      acc_ff, acc_in;
   logic                      pend_ff, pend_in;
   logic [7:0]                rd_data_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff;
   logic                      out_bvalid_ff;
   logic                      out_last_ff;
   logic                      out_acc_ff;
   logic [LW-1:0]             out_level_ff;

   logic [brf_pkg::CAP_W-1:0] eff_log2;
   logic [AW-1:0]             mask;
   logic [LW-1:0]             cap;
   logic [BW-1:0]             len_sat;
   logic [BW-1:0]             grant;
   logic                      room;
   logic                      mem_we;
   logic                      load_any;

   // effective capacity, clamped to the store depth
   always_comb begin
      eff_log2 = (cap_log2_ff > brf_pkg::CAP_RESET) ? brf_pkg::CAP_RESET : cap_log2_ff;
      cap      = LW'(1) << eff_log2;
      mask     = AW'(cap - LW'(1));
      room     = fill_ff < cap;
   end

   // burst grant: request saturated to the burst limit, then to the fill level
   always_comb begin
      len_sat = (read_length > BW'(brf_pkg::MAX_BURST)) ? BW'(brf_pkg::MAX_BURST)
                                                        : BW'(read_length);
      grant   = (fill_ff < LW'(len_sat)) ? fill_ff[BW-1:0] : len_sat;
   end

   assign load_any = cmd.load_byte || cmd.load_single;
   assign mem_we   = cmd.start && (action == brf_pkg::ACT_WRITE) && room;

   // status to the controller
   always_comb begin
      status.burst_grant = (action inside {brf_pkg::ACT_POP, brf_pkg::ACT_PEEK})
                           && (grant != '0);
      status.out_free    = !out_valid_ff || rsp_tready;
      status.pending     = pend_ff;
      status.issue_left  = issue_cnt_ff != '0;
      status.last_load   = load_cnt_ff == BW'(1);
   end

   // pointer, fill and burst counter updates
   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      addr_in      = addr_ff;
      issue_cnt_in = issue_cnt_ff;
      load_cnt_in  = load_cnt_ff;
      if (csr_wr_en) begin
         rp_in   = '0;
         wp_in   = '0;
         fill_in = '0;
      end else if (cmd.start) begin
         case (action)
            brf_pkg::ACT_WRITE: begin
               acc_in = room;
               if (room) begin
                  wp_in   = (wp_ff + AW'(1)) & mask;
                  fill_in = fill_ff + LW'(1);
               end
            end
            brf_pkg::ACT_CLEAR: begin
               rp_in   = '0;
               wp_in   = '0;
               fill_in = '0;
               acc_in  = 1'b1;
            end
            default: begin
               // pop or peek
               acc_in       = grant != '0;
               addr_in      = rp_ff;
               issue_cnt_in = grant;
               load_cnt_in  = grant;
               if ((action == brf_pkg::ACT_POP) && (grant != '0)) begin
                  rp_in   = (rp_ff + AW'(grant)) & mask;
                  fill_in = fill_ff - LW'(grant);
               end
            end
         endcase
      end
      if (cmd.issue) begin
         addr_in      = (addr_ff + AW'(1)) & mask;
         issue_cnt_in = issue_cnt_ff - BW'(1);
      end
      if (cmd.load_byte) begin
         load_cnt_in = load_cnt_ff - BW'(1);
      end
   end

   // read data pending and result register occupancy
   always_comb begin
      pend_in = pend_ff;
      if (cmd.issue) begin
         pend_in = 1'b1;
      end else if (cmd.load_byte) begin
         pend_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_any) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff  <= brf_pkg::CAP_RESET;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         issue_cnt_ff <= '0;
         load_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_log2_ff <= csr_wr_data;
         end
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         issue_cnt_ff <= issue_cnt_in;
         load_cnt_ff  <= load_cnt_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // burst address and granted flag
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      acc_ff  <= acc_in;
   end

   // byte store write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= data_byte;
      end
   end

   // byte store read port, registered
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         out_byte_ff   <= rd_data_ff;
         out_bvalid_ff <= 1'b1;
         out_last_ff   <= load_cnt_ff == BW'(1);
         out_acc_ff    <= 1'b1;
         out_level_ff  <= fill_ff;
      end else if (cmd.load_single) begin
         out_byte_ff   <= '0;
         out_bvalid_ff <= 1'b0;
         out_last_ff   <= 1'b1;
         out_acc_ff    <= acc_ff;
         out_level_ff  <= fill_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte       = out_byte_ff;
   assign rsp_byte_valid = out_bvalid_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_accepted   = out_acc_ff;
   assign rsp_level      = out_level_ff;

endmodule

### hw/rtl/byte_ring_fifo_with_peek.sv
// top level of the circular byte fifo with peek
`timescale 1ns / 1ps

// Circular byte FIFO with peek, up to 1024 slots.
// Request channel: req_tuser carries the kind (write, pop, peek, clear),
// req_tdata the byte to write and the requested burst length.
// A write stores one byte unless the FIFO is full; pop and peek emit up to
// 16 bytes (clamped to the fill level), pop also consuming them; clear empties.
// Response channel: one transaction per write, clear or empty read, and one
// per byte for a granted read; tlast marks the final transaction of a request.
// Every response carries the fill level after the request.
// Order: after acceptance, a write or clear passes the state register and then
// the result register; a read burst also passes the read data register. Only one
// request is in work at a time; a burst then streams one byte per cycle, while
// the receiver accepts, from the registered read port of the byte store.
// A stalled receiver holds the response register; the burst waits with at most
// one byte held in the read data register, and no byte is lost.
// Reset empties the FIFO and sets the capacity to 1024 slots; a write on the
// csr port sets log2 of the capacity and also empties the FIFO. Write csr only
// while no request is in work.
module byte_ring_fifo_with_peek (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,  // capacity_log2
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [7:0] data_byte, [12:8] read_length, [15:13] zero
   input  logic [1:0]  req_tuser,    // [1:0] action
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] out_byte, [18:8] fill_level, [23:19] zero
   output logic [1:0]  rsp_tuser,    // [0] byte_valid, [1] accepted
   output logic        rsp_tlast     // last_of_run
);

   brf_pkg::brf_cmd_type    cmd;
   brf_pkg::brf_status_type status;

   logic [7:0]                  rsp_byte;
   logic                        rsp_byte_valid;
   logic                        rsp_accepted;
   logic [brf_pkg::LEVEL_W-1:0] rsp_level;

   // controller
   brf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   brf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .action         (brf_pkg::brf_action_type'(req_tuser)),
      .data_byte      (req_tdata[7:0]),
      .read_length    (req_tdata[12:8]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_byte       (rsp_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_tlast),
      .rsp_accepted   (rsp_accepted),
      .rsp_level      (rsp_level)
   );

   // response packing
   assign rsp_tdata = {5'b0, rsp_level, rsp_byte};
   assign rsp_tuser = {rsp_accepted, rsp_byte_valid};

   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // fill level never exceeds the store depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:8] <= 11'(brf_pkg::MAX_DEPTH))
      else $error("fill level above store depth");

   // a response without a byte is always the only one of its request
   a_nobyte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("byteless response not marked last");

   // read data is never pending outside a burst with a granted byte
   a_pending_granted: assert property (@(posedge clock) disable iff (reset)
      status.pending |-> !req_tready)
      else $error("read data pending while idle");

endmodule
